// ===== sv/chip8_instruction_execute_assert.svh =====
`ifndef CHIP8_INSTRUCTION_EXECUTE_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define C8E_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define C8E_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/c8e_pkg.sv =====
package c8e_pkg;

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_Y,
        ST_EXEC,
        ST_FLAG,
        ST_MOD,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_BCD,
        ST_ST_RD,
        ST_ST_WR,
        ST_LD_RD,
        ST_LD_WR,
        ST_DONE
    } ctl_state_t;

    // Datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_READ_Y,
        CMD_EXEC,
        CMD_FLAG,
        CMD_MOD,
        CMD_DRAW_RD,
        CMD_DRAW_WR,
        CMD_BCD,
        CMD_ST_RD,
        CMD_ST_WR,
        CMD_LD_RD,
        CMD_LD_WR,
        CMD_DONE
    } dp_cmd_t;

    // What follows the execute cycle
    typedef enum logic [2:0] {
        KIND_PLAIN,
        KIND_FLAG,
        KIND_DRAW,
        KIND_BCD,
        KIND_STORE,
        KIND_LOAD
    } exec_kind_t;

    typedef struct packed {
        logic       clear_done;
        exec_kind_t kind;
        logic       mod_done;
        logic       rows_zero;
        logic       row_last;
        logic       bcd_last;
        logic       k_last;
        logic       out_free;
    } dp_status_t;

    // Request types
    localparam logic [1:0] REQ_EXEC  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_ROW   = 2'd3;

    // Opcode groups (top nibble)
    localparam logic [3:0] OP_SYS   = 4'h0;
    localparam logic [3:0] OP_JP    = 4'h1;
    localparam logic [3:0] OP_CALL  = 4'h2;
    localparam logic [3:0] OP_SE_K  = 4'h3;
    localparam logic [3:0] OP_SNE_K = 4'h4;
    localparam logic [3:0] OP_SE_V  = 4'h5;
    localparam logic [3:0] OP_LD_K  = 4'h6;
    localparam logic [3:0] OP_ADD_K = 4'h7;
    localparam logic [3:0] OP_ALU   = 4'h8;
    localparam logic [3:0] OP_SNE_V = 4'h9;
    localparam logic [3:0] OP_LD_I  = 4'hA;
    localparam logic [3:0] OP_JP_V0 = 4'hB;
    localparam logic [3:0] OP_RND   = 4'hC;
    localparam logic [3:0] OP_DRW   = 4'hD;
    localparam logic [3:0] OP_MISC  = 4'hF;

    // ALU functions (low nibble)
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // Low-byte functions
    localparam logic [7:0] SYS_CLS  = 8'hE0;
    localparam logic [7:0] SYS_RET  = 8'hEE;
    localparam logic [7:0] F_GET_DT = 8'h07;
    localparam logic [7:0] F_SET_DT = 8'h15;
    localparam logic [7:0] F_SET_ST = 8'h18;
    localparam logic [7:0] F_ADD_I  = 8'h1E;
    localparam logic [7:0] F_FONT   = 8'h29;
    localparam logic [7:0] F_BCD    = 8'h33;
    localparam logic [7:0] F_STORE  = 8'h55;
    localparam logic [7:0] F_LOAD   = 8'h65;

    localparam logic [3:0]  FLAG_REG = 4'hF;
    localparam logic [11:0] PC_RESET = 12'h200;

endpackage

// ===== sv/c8e_ctrl.sv =====
module c8e_ctrl
    import c8e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_req,
    input  dp_status_t status,
    output logic       in_stall,
    output dp_cmd_t    cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        in_stall   = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd = CMD_CLEAR;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = (in_req == REQ_EXEC) ? ST_READ_Y : ST_DONE;
                end
            end
            ST_READ_Y:
            begin
                cmd        = CMD_READ_Y;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd = CMD_EXEC;
                case (status.kind)
                    KIND_FLAG:  state_next = ST_FLAG;
                    KIND_DRAW:  state_next = ST_MOD;
                    KIND_BCD:   state_next = ST_BCD;
                    KIND_STORE: state_next = ST_ST_RD;
                    KIND_LOAD:  state_next = ST_LD_RD;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_FLAG:
            begin
                cmd        = CMD_FLAG;
                state_next = ST_DONE;
            end
            ST_MOD:
            begin
                cmd = CMD_MOD;
                if (status.mod_done)
                begin
                    state_next = status.rows_zero ? ST_FLAG : ST_DRAW_RD;
                end
            end
            ST_DRAW_RD:
            begin
                cmd        = CMD_DRAW_RD;
                state_next = ST_DRAW_WR;
            end
            ST_DRAW_WR:
            begin
                cmd        = CMD_DRAW_WR;
                state_next = status.row_last ? ST_FLAG : ST_DRAW_RD;
            end
            ST_BCD:
            begin
                cmd = CMD_BCD;
                if (status.bcd_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ST_RD:
            begin
                cmd        = CMD_ST_RD;
                state_next = ST_ST_WR;
            end
            ST_ST_WR:
            begin
                cmd        = CMD_ST_WR;
                state_next = status.k_last ? ST_DONE : ST_ST_RD;
            end
            ST_LD_RD:
            begin
                cmd        = CMD_LD_RD;
                state_next = ST_LD_WR;
            end
            ST_LD_WR:
            begin
                cmd        = CMD_LD_WR;
                state_next = status.k_last ? ST_DONE : ST_LD_RD;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd        = CMD_DONE;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/c8e_datapath.sv =====
module c8e_datapath
    import c8e_pkg::*;
#(
    parameter int MEMORY_BYTES  = 4096,
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32,
    parameter int STACK_DEPTH   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [1:0]  req_type,
    input  logic [15:0] opcode,
    input  logic [11:0] address,
    input  logic [7:0]  write_data,
    input  logic [7:0]  random_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic [63:0] pixel_row,
    output logic [11:0] next_pc,
    output logic [11:0] index_value,
    output logic [7:0]  flag_value,
    output logic [7:0]  sound_value
);

    localparam int AW = $clog2(MEMORY_BYTES);
    localparam int HW = $clog2(SCREEN_HEIGHT);
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Reduce an address modulo the memory size
    function automatic logic [AW-1:0] mod_mem(input logic [12:0] v);
        logic [12:0] t;
        t = v;
        for (int i = 0; i < 8; i++)
        begin
            if (t >= 13'(MEMORY_BYTES))
            begin
                t = t - 13'(MEMORY_BYTES);
            end
        end
        return t[AW-1:0];
    endfunction

    // Reduce the stack pointer modulo the stack depth
    function automatic logic [SW-1:0] mod_stack(input logic [3:0] s);
        logic [4:0] t;
        t = {1'b0, s};
        for (int i = 0; i < 8; i++)
        begin
            if (t >= 5'(STACK_DEPTH))
            begin
                t = t - 5'(STACK_DEPTH);
            end
        end
        return t[SW-1:0];
    endfunction

    // Storage
    logic [7:0]  mem [MEMORY_BYTES];
    logic [7:0]  gp_mem [16];
    logic [63:0] fr_mem [SCREEN_HEIGHT];
    logic [11:0] stack_reg [STACK_DEPTH];
    logic [15:0] gp_valid_reg;
    logic [SCREEN_HEIGHT-1:0] fr_valid_reg;

    // Architectural and work registers
    logic [11:0]   pc_reg;
    logic [11:0]   i_reg;
    logic [3:0]    sp_reg;
    logic [7:0]    dt_reg;
    logic [7:0]    st_reg;
    logic [7:0]    vf_reg;
    logic [1:0]    req_reg;
    logic [15:0]   op_reg;
    logic [7:0]    rnd_reg;
    logic          row_ok_reg;
    logic [7:0]    vx_reg;
    logic [7:0]    vy_reg;
    logic          flag_reg;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [HW-1:0] yy_reg;
    logic [3:0]    r_reg;
    logic [3:0]    k_reg;
    logic [1:0]    bcd_idx_reg;
    logic [3:0]    bcd_reg [3];

    // Output register
    logic          out_valid_reg;
    logic [7:0]    read_data_reg;
    logic [63:0]   pixel_row_reg;
    logic [11:0]   next_pc_reg;
    logic [11:0]   index_value_reg;
    logic [7:0]    flag_value_reg;
    logic [7:0]    sound_value_reg;

    // Memory ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata_reg;
    logic          gp_we;
    logic [3:0]    gp_waddr;
    logic [7:0]    gp_wdata;
    logic [3:0]    gp_raddr;
    logic [7:0]    gp_rdata_reg;
    logic          fr_we;
    logic [HW-1:0] fr_waddr;
    logic [63:0]   fr_wdata;
    logic          fr_re;
    logic [HW-1:0] fr_raddr;
    logic [63:0]   fr_rdata_reg;

    // Opcode fields
    logic [3:0]  op_top;
    logic [3:0]  op_x;
    logic [3:0]  op_y;
    logic [3:0]  op_n;
    logic [7:0]  op_kk;
    logic [11:0] op_nnn;

    logic [7:0]  vy_now;
    logic [7:0]  alu_res;
    logic        alu_we;
    logic        exec_flag;
    logic [8:0]  sum9;
    logic [1:0]  bcd_h;
    logic [6:0]  bcd_rem;
    logic [14:0] bcd_prod;
    logic [3:0]  bcd_t;
    logic [6:0]  bcd_o;
    logic [63:0] mask;
    logic [3:0]  sp_inc;

    assign op_top = op_reg[15:12];
    assign op_x   = op_reg[11:8];
    assign op_y   = op_reg[7:4];
    assign op_n   = op_reg[3:0];
    assign op_kk  = op_reg[7:0];
    assign op_nnn = op_reg[11:0];
    assign vy_now = gp_rdata_reg;
    assign sum9   = {1'b0, vx_reg} + {1'b0, vy_now};
    assign sp_inc = sp_reg + 4'd1;

    // Status back to the controller
    always_comb
    begin
        status.kind = KIND_PLAIN;
        case (op_top)
            OP_ALU:
            begin
                if (op_n == ALU_ADD || op_n == ALU_SUB || op_n == ALU_SHR ||
                    op_n == ALU_SUBN || op_n == ALU_SHL)
                begin
                    status.kind = KIND_FLAG;
                end
            end
            OP_DRW:
            begin
                status.kind = KIND_DRAW;
            end
            OP_MISC:
            begin
                if (op_kk == F_BCD)
                begin
                    status.kind = KIND_BCD;
                end
                else if (op_kk == F_STORE)
                begin
                    status.kind = KIND_STORE;
                end
                else if (op_kk == F_LOAD)
                begin
                    status.kind = KIND_LOAD;
                end
            end
            default:
            begin
                status.kind = KIND_PLAIN;
            end
        endcase
        status.clear_done = (clr_cnt_reg == AW'(MEMORY_BYTES - 1));
        status.mod_done   = (vx_reg < 8'(SCREEN_WIDTH)) && (vy_reg < 8'(SCREEN_HEIGHT));
        status.rows_zero  = (op_n == 4'd0);
        status.row_last   = (r_reg == op_n - 4'd1);
        status.bcd_last   = (bcd_idx_reg == 2'd2);
        status.k_last     = (k_reg == op_x);
        status.out_free   = !out_valid_reg || !out_stall;
    end

    // ALU result and flag for register ops
    always_comb
    begin
        alu_res   = 8'd0;
        alu_we    = 1'b0;
        exec_flag = 1'b0;
        case (op_top)
            OP_LD_K:
            begin
                alu_we  = 1'b1;
                alu_res = op_kk;
            end
            OP_ADD_K:
            begin
                alu_we  = 1'b1;
                alu_res = vx_reg + op_kk;
            end
            OP_RND:
            begin
                alu_we  = 1'b1;
                alu_res = rnd_reg & op_kk;
            end
            OP_MISC:
            begin
                if (op_kk == F_GET_DT)
                begin
                    alu_we  = 1'b1;
                    alu_res = dt_reg;
                end
            end
            OP_ALU:
            begin
                alu_we = 1'b1;
                case (op_n)
                    ALU_MOV: alu_res = vy_now;
                    ALU_OR:  alu_res = vx_reg | vy_now;
                    ALU_AND: alu_res = vx_reg & vy_now;
                    ALU_XOR: alu_res = vx_reg ^ vy_now;
                    ALU_ADD:
                    begin
                        alu_res   = sum9[7:0];
                        exec_flag = sum9[8];
                    end
                    ALU_SUB:
                    begin
                        alu_res   = vx_reg - vy_now;
                        exec_flag = (vx_reg >= vy_now);
                    end
                    ALU_SHR:
                    begin
                        alu_res   = {1'b0, vx_reg[7:1]};
                        exec_flag = vx_reg[0];
                    end
                    ALU_SUBN:
                    begin
                        alu_res   = vy_now - vx_reg;
                        exec_flag = (vy_now >= vx_reg);
                    end
                    ALU_SHL:
                    begin
                        alu_res   = {vx_reg[6:0], 1'b0};
                        exec_flag = vx_reg[7];
                    end
                    default:
                    begin
                        alu_we = 1'b0;
                    end
                endcase
            end
            default:
            begin
                alu_we = 1'b0;
            end
        endcase
    end

    // Split Vx into decimal digits
    always_comb
    begin
        if (vx_reg >= 8'd200)
        begin
            bcd_h = 2'd2;
        end
        else if (vx_reg >= 8'd100)
        begin
            bcd_h = 2'd1;
        end
        else
        begin
            bcd_h = 2'd0;
        end
        bcd_rem  = 7'(vx_reg - 8'(bcd_h) * 8'd100);
        bcd_prod = 15'(bcd_rem) * 15'd205;
        bcd_t    = bcd_prod[14:11];
        bcd_o    = bcd_rem - 7'(bcd_t) * 7'd10;
    end

    // Place the sprite byte at its wrapped columns
    always_comb
    begin
        logic [6:0] xx;
        mask = '0;
        for (int c = 0; c < 8; c++)
        begin
            xx = 7'(vx_reg) + 7'(c);
            if (xx >= 7'(SCREEN_WIDTH))
            begin
                xx = xx - 7'(SCREEN_WIDTH);
            end
            if (mem_rdata_reg[7 - c])
            begin
                mask[6'd63 - xx[5:0]] = 1'b1;
            end
        end
    end

    // Port selection per command
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = 8'd0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        gp_we     = 1'b0;
        gp_waddr  = 4'd0;
        gp_wdata  = 8'd0;
        gp_raddr  = 4'd0;
        fr_we     = 1'b0;
        fr_waddr  = '0;
        fr_wdata  = '0;
        fr_re     = 1'b0;
        fr_raddr  = '0;
        case (cmd)
            CMD_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
            end
            CMD_LOAD:
            begin
                gp_raddr = opcode[11:8];
                if (req_type == REQ_WRITE)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = mod_mem({1'b0, address});
                    mem_wdata = write_data;
                end
                else if (req_type == REQ_READ)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = mod_mem({1'b0, address});
                end
                else if (req_type == REQ_ROW)
                begin
                    fr_re    = 1'b1;
                    fr_raddr = address[HW-1:0];
                end
            end
            CMD_READ_Y:
            begin
                gp_raddr = (op_top == OP_JP_V0) ? 4'd0 : op_y;
            end
            CMD_EXEC:
            begin
                gp_we    = alu_we;
                gp_waddr = op_x;
                gp_wdata = alu_res;
            end
            CMD_FLAG:
            begin
                gp_we    = 1'b1;
                gp_waddr = FLAG_REG;
                gp_wdata = {7'd0, flag_reg};
            end
            CMD_DRAW_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = ptr_reg;
                fr_re     = 1'b1;
                fr_raddr  = yy_reg;
            end
            CMD_DRAW_WR:
            begin
                fr_we    = 1'b1;
                fr_waddr = yy_reg;
                fr_wdata = fr_rdata_reg ^ mask;
            end
            CMD_BCD:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = {4'd0, bcd_reg[bcd_idx_reg]};
            end
            CMD_ST_RD:
            begin
                gp_raddr = k_reg;
            end
            CMD_ST_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = gp_rdata_reg;
            end
            CMD_LD_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = ptr_reg;
            end
            CMD_LD_WR:
            begin
                gp_we    = 1'b1;
                gp_waddr = k_reg;
                gp_wdata = mem_rdata_reg;
            end
            default:
            begin
                gp_raddr = 4'd0;
            end
        endcase
    end

    // Main memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // Register file
    always_ff @(posedge clk)
    begin
        if (gp_we)
        begin
            gp_mem[gp_waddr] <= gp_wdata;
        end
        gp_rdata_reg <= gp_valid_reg[gp_raddr] ? gp_mem[gp_raddr] : 8'd0;
    end

    // Frame store
    always_ff @(posedge clk)
    begin
        if (fr_we)
        begin
            fr_mem[fr_waddr] <= fr_wdata;
        end
        if (fr_re)
        begin
            fr_rdata_reg <= fr_valid_reg[fr_raddr] ? fr_mem[fr_raddr] : 64'd0;
        end
    end

    // Work registers that need no reset
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                req_reg    <= req_type;
                op_reg     <= opcode;
                rnd_reg    <= random_byte;
                row_ok_reg <= (address < 12'(SCREEN_HEIGHT));
            end
            CMD_READ_Y:
            begin
                vx_reg <= gp_rdata_reg;
            end
            CMD_EXEC:
            begin
                vy_reg      <= vy_now;
                flag_reg    <= exec_flag;
                r_reg       <= 4'd0;
                k_reg       <= 4'd0;
                bcd_idx_reg <= 2'd0;
                ptr_reg     <= mod_mem({1'b0, i_reg});
                bcd_reg[0]  <= {2'd0, bcd_h};
                bcd_reg[1]  <= bcd_t;
                bcd_reg[2]  <= bcd_o[3:0];
            end
            CMD_MOD:
            begin
                if (vx_reg >= 8'(SCREEN_WIDTH))
                begin
                    vx_reg <= vx_reg - 8'(SCREEN_WIDTH);
                end
                if (vy_reg >= 8'(SCREEN_HEIGHT))
                begin
                    vy_reg <= vy_reg - 8'(SCREEN_HEIGHT);
                end
                yy_reg <= vy_reg[HW-1:0];
            end
            CMD_DRAW_WR:
            begin
                flag_reg <= flag_reg | (|(fr_rdata_reg & mask));
                ptr_reg  <= (ptr_reg == AW'(MEMORY_BYTES - 1)) ? '0 : ptr_reg + AW'(1);
                yy_reg   <= (yy_reg == HW'(SCREEN_HEIGHT - 1)) ? '0 : yy_reg + HW'(1);
                r_reg    <= r_reg + 4'd1;
            end
            CMD_BCD:
            begin
                ptr_reg     <= (ptr_reg == AW'(MEMORY_BYTES - 1)) ? '0 : ptr_reg + AW'(1);
                bcd_idx_reg <= bcd_idx_reg + 2'd1;
            end
            CMD_ST_WR, CMD_LD_WR:
            begin
                ptr_reg <= (ptr_reg == AW'(MEMORY_BYTES - 1)) ? '0 : ptr_reg + AW'(1);
                k_reg   <= k_reg + 4'd1;
            end
            default:
            begin
                r_reg <= r_reg;
            end
        endcase
    end

    // Architectural state, valid bits and result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg          <= PC_RESET;
            i_reg           <= 12'd0;
            sp_reg          <= 4'd0;
            dt_reg          <= 8'd0;
            st_reg          <= 8'd0;
            vf_reg          <= 8'd0;
            clr_cnt_reg     <= '0;
            gp_valid_reg    <= '0;
            fr_valid_reg    <= '0;
            out_valid_reg   <= 1'b0;
            read_data_reg   <= 8'd0;
            pixel_row_reg   <= 64'd0;
            next_pc_reg     <= 12'd0;
            index_value_reg <= 12'd0;
            flag_value_reg  <= 8'd0;
            sound_value_reg <= 8'd0;
            for (int s = 0; s < STACK_DEPTH; s++)
            begin
                stack_reg[s] <= 12'd0;
            end
        end
        else
        begin
            // Drop the result once taken
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (gp_we)
            begin
                gp_valid_reg[gp_waddr] <= 1'b1;
                if (gp_waddr == FLAG_REG)
                begin
                    vf_reg <= gp_wdata;
                end
            end
            if (fr_we)
            begin
                fr_valid_reg[fr_waddr] <= 1'b1;
            end
            case (cmd)
                CMD_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                end
                CMD_LOAD:
                begin
                    if (req_type == REQ_EXEC)
                    begin
                        pc_reg <= pc_reg + 12'd2;
                    end
                end
                CMD_EXEC:
                begin
                    case (op_top)
                        OP_SYS:
                        begin
                            if (op_kk == SYS_CLS)
                            begin
                                fr_valid_reg <= '0;
                            end
                            else if (op_kk == SYS_RET)
                            begin
                                pc_reg <= stack_reg[mod_stack(sp_reg)];
                                sp_reg <= sp_reg - 4'd1;
                            end
                        end
                        OP_JP:
                        begin
                            pc_reg <= op_nnn;
                        end
                        OP_CALL:
                        begin
                            sp_reg                    <= sp_inc;
                            stack_reg[mod_stack(sp_inc)] <= pc_reg;
                            pc_reg                    <= op_nnn;
                        end
                        OP_SE_K:
                        begin
                            if (vx_reg == op_kk)
                            begin
                                pc_reg <= pc_reg + 12'd2;
                            end
                        end
                        OP_SNE_K:
                        begin
                            if (vx_reg != op_kk)
                            begin
                                pc_reg <= pc_reg + 12'd2;
                            end
                        end
                        OP_SE_V:
                        begin
                            if (vx_reg == vy_now)
                            begin
                                pc_reg <= pc_reg + 12'd2;
                            end
                        end
                        OP_SNE_V:
                        begin
                            if (vx_reg != vy_now)
                            begin
                                pc_reg <= pc_reg + 12'd2;
                            end
                        end
                        OP_LD_I:
                        begin
                            i_reg <= op_nnn;
                        end
                        OP_JP_V0:
                        begin
                            pc_reg <= {4'd0, vy_now} + op_nnn;
                        end
                        OP_MISC:
                        begin
                            if (op_kk == F_SET_DT)
                            begin
                                dt_reg <= vx_reg;
                            end
                            else if (op_kk == F_SET_ST)
                            begin
                                st_reg <= vx_reg;
                            end
                            else if (op_kk == F_ADD_I)
                            begin
                                i_reg <= i_reg + {4'd0, vx_reg};
                            end
                            else if (op_kk == F_FONT)
                            begin
                                i_reg <= {6'd0, vx_reg[3:0], 2'd0} + {8'd0, vx_reg[3:0]};
                            end
                        end
                        default:
                        begin
                            pc_reg <= pc_reg;
                        end
                    endcase
                end
                CMD_DONE:
                begin
                    out_valid_reg   <= 1'b1;
                    read_data_reg   <= (req_reg == REQ_READ) ? mem_rdata_reg : 8'd0;
                    pixel_row_reg   <= (req_reg == REQ_ROW && row_ok_reg) ?
                                       fr_rdata_reg : 64'd0;
                    next_pc_reg     <= pc_reg;
                    index_value_reg <= i_reg;
                    flag_value_reg  <= vf_reg;
                    sound_value_reg <= st_reg;
                end
                default:
                begin
                    sp_reg <= sp_reg;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign pixel_row   = pixel_row_reg;
    assign next_pc     = next_pc_reg;
    assign index_value = index_value_reg;
    assign flag_value  = flag_value_reg;
    assign sound_value = sound_value_reg;

endmodule

// ===== sv/chip8_instruction_execute.sv =====
// Interpreter core that executes one opcode, memory access or row read per beat.
// Input channel: in_valid/in_stall with req_type, opcode, address, write_data
// and random_byte; a beat is taken when in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall with one result beat per input beat.
// One item is in flight at a time; the controller sequences the memories.
// Memory writes, memory reads and row reads go from the load straight to done.
// Opcodes pass read-Y, execute and done; flag-setting ALU ops add a flag write,
// Fx33 writes three digits, and Fx55 and Fx65 do one memory port access per byte.
// Dxyn folds Vx and Vy onto the screen by repeated modulo steps; each
// sprite row is then a memory read and a frame store read-modify-write,
// and the flag write follows the last row.
// Reset: architectural state and valid bits take their reset values and the
// block runs a clearing pass over main memory, with in_stall high throughout.
// A stalled result beat holds; the block finishes the next item and waits
// for the output register to free up before it accepts another one.
module chip8_instruction_execute
    import c8e_pkg::*;
#(
    parameter int MEMORY_BYTES  = 4096,
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32,
    parameter int STACK_DEPTH   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [15:0] opcode,
    input  logic [11:0] address,
    input  logic [7:0]  write_data,
    input  logic [7:0]  random_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic [63:0] pixel_row,
    output logic [11:0] next_pc,
    output logic [11:0] index_value,
    output logic [7:0]  flag_value,
    output logic [7:0]  sound_value
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer
    c8e_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_req   (req_type),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // Storage and arithmetic
    c8e_datapath #(
        .MEMORY_BYTES  (MEMORY_BYTES),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .req_type    (req_type),
        .opcode      (opcode),
        .address     (address),
        .write_data  (write_data),
        .random_byte (random_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .pixel_row   (pixel_row),
        .next_pc     (next_pc),
        .index_value (index_value),
        .flag_value  (flag_value),
        .sound_value (sound_value)
    );

endmodule

// ===== sv/c8e_checker.sv =====
`include "chip8_instruction_execute_assert.svh"

module c8e_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [11:0] next_pc,
    input logic [7:0]  flag_value
);

    // One item at a time: busy right after a beat is taken
    `C8E_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // A new result only appears while the input side is held off
    `C8E_ASSERT_NOW(a_result_while_busy, $rose(out_valid), $past(in_stall))

    // Hold a stalled result beat
    `C8E_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(next_pc) && $stable(flag_value))

endmodule

bind chip8_instruction_execute c8e_checker u_c8e_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .next_pc    (next_pc),
    .flag_value (flag_value)
);
